@@ sv/base32_stream_encoder_macros.svh @@
// Assertion macros shared by the base32 stream encoder RTL.
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef BASE32_STREAM_ENCODER_MACROS_SVH
`define BASE32_STREAM_ENCODER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define B32_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("base32 encoder check failed");
// Next-cycle implication.
`define B32_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("base32 encoder check failed");
`else
`define B32_ASSERT_NOW(label, ante, cons)
`define B32_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ sv/b32enc_pkg.sv @@
// Types, constants and the alphabet function of the base32 stream encoder.
// No dependencies.
package b32enc_pkg;

    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Number of leftover bits held between bytes.
    localparam logic [2:0] PEND_0 = 3'd0;
    localparam logic [2:0] PEND_1 = 3'd1;
    localparam logic [2:0] PEND_2 = 3'd2;
    localparam logic [2:0] PEND_3 = 3'd3;
    localparam logic [2:0] PEND_4 = 3'd4;

    localparam logic [6:0] CHAR_A     = 7'h61;  // 'a'
    localparam logic [6:0] CHAR_2     = 7'h32;  // '2'
    localparam logic [4:0] LETTER_CNT = 5'd26;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_of_run;
        logic       message_tail;
    } b32_res_t;

    // Up to two characters produced by one item.
    typedef struct packed {
        logic [1:0] count;
        b32_res_t   res0;
        b32_res_t   res1;
    } b32_pair_t;

    function automatic logic [6:0] b32_char(input logic [4:0] grp);
        logic [6:0] c;
        if (grp < LETTER_CNT) begin
            c = CHAR_A + {2'b00, grp};
        end else begin
            c = CHAR_2 + {2'b00, grp - LETTER_CNT};
        end
        return c;
    endfunction

endpackage

@@ sv/b32enc_codec.sv @@
// Bit-phase state and 5-bit grouping for one item of the base32 encoder.
// Depends on b32enc_pkg and base32_stream_encoder_macros.svh.
`include "base32_stream_encoder_macros.svh"
module b32enc_codec (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  take,
    input  logic                  command,
    input  logic [7:0]            data_byte,
    output b32enc_pkg::b32_pair_t pair
);
    import b32enc_pkg::*;

    logic [2:0] pend_reg, pend_next;
    logic [4:0] resid_reg, resid_next;
    logic [4:0] grp0, grp1;
    logic [1:0] cnt;
    logic       tail;

    always_comb begin
        grp0       = 5'd0;
        grp1       = 5'd0;
        cnt        = 2'd0;
        tail       = 1'b0;
        pend_next  = PEND_0;
        resid_next = 5'd0;
        if (command == CMD_FLUSH) begin
            grp0 = resid_reg;
            tail = 1'b1;
            cnt  = (pend_reg inside {[PEND_1:PEND_4]}) ? 2'd1 : 2'd0;
        end else begin
            case (pend_reg)
                PEND_3: begin
                    grp0       = resid_reg | {3'b000, data_byte[7:6]};
                    grp1       = data_byte[5:1];
                    cnt        = 2'd2;
                    resid_next = {data_byte[0], 4'b0000};
                    pend_next  = PEND_1;
                end
                PEND_1: begin
                    grp0       = resid_reg | {1'b0, data_byte[7:4]};
                    cnt        = 2'd1;
                    resid_next = {data_byte[3:0], 1'b0};
                    pend_next  = PEND_4;
                end
                PEND_4: begin
                    grp0       = resid_reg | {4'b0000, data_byte[7]};
                    grp1       = data_byte[6:2];
                    cnt        = 2'd2;
                    resid_next = {data_byte[1:0], 3'b000};
                    pend_next  = PEND_2;
                end
                PEND_2: begin
                    grp0 = resid_reg | {2'b00, data_byte[7:5]};
                    grp1 = data_byte[4:0];
                    cnt  = 2'd2;
                end
                default: begin
                    // empty phase; unreachable codes drop the residual
                    grp0       = data_byte[7:3];
                    cnt        = 2'd1;
                    resid_next = {data_byte[2:0], 2'b00};
                    pend_next  = PEND_3;
                end
            endcase
        end
    end

    always_comb begin
        pair.count             = cnt;
        pair.res0.out_char     = b32_char(grp0);
        pair.res0.last_of_run  = (cnt == 2'd1);
        pair.res0.message_tail = tail;
        pair.res1.out_char     = b32_char(grp1);
        pair.res1.last_of_run  = 1'b1;
        pair.res1.message_tail = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= PEND_0;
            resid_reg <= 5'd0;
        end else if (take) begin
            pend_reg  <= pend_next;
            resid_reg <= resid_next;
        end
    end

    `B32_ASSERT_NOW(a_pend_range, 1'b1, pend_reg <= PEND_4)
    `B32_ASSERT_NOW(a_empty_resid, pend_reg == PEND_0, resid_reg == 5'd0)
    `B32_ASSERT_NXT(a_flush_clears, take && command == CMD_FLUSH, pend_reg == PEND_0)

endmodule

@@ sv/b32enc_outq.sv @@
// Three-entry result queue: loads up to two characters, sends one per cycle while m_ready is high.
// Depends on b32enc_pkg and base32_stream_encoder_macros.svh.
`include "base32_stream_encoder_macros.svh"
module b32enc_outq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  b32enc_pkg::b32_pair_t pair,
    output logic                  space,
    output logic                  m_valid,
    input  logic                  m_ready,
    output b32enc_pkg::b32_res_t  head
);
    import b32enc_pkg::*;

    localparam int unsigned DEPTH = 3;

    b32_res_t   slot_reg [DEPTH];
    b32_res_t   slot_next[DEPTH];
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] push_n;
    logic [1:0] base;
    logic       pop;

    assign m_valid = (cnt_reg != 2'd0);
    assign head    = slot_reg[0];
    assign space   = (cnt_reg <= 2'd1);
    assign pop     = m_valid && m_ready;
    assign push_n  = push ? pair.count : 2'd0;
    assign base    = cnt_reg - {1'b0, pop};
    assign cnt_next = base + push_n;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (pop && i < DEPTH - 1) begin
                slot_next[i] = slot_reg[i + 1];
            end else begin
                slot_next[i] = slot_reg[i];
            end
            if (push_n != 2'd0 && base == 2'(i)) begin
                slot_next[i] = pair.res0;
            end
            if (push_n == 2'd2 && base + 2'd1 == 2'(i)) begin
                slot_next[i] = pair.res1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            slot_reg[i] <= slot_next[i];
        end
    end

    `B32_ASSERT_NOW(a_push_room, push_n != 2'd0, cnt_reg <= 2'd1)
    `B32_ASSERT_NXT(a_drain, pop && push_n == 2'd0, cnt_reg == $past(cnt_reg) - 2'd1)
    `B32_ASSERT_NOW(a_tail_last, m_valid && head.message_tail, head.last_of_run)

endmodule

@@ sv/base32_stream_encoder.sv @@
// Top level of the streaming base32 encoder (lowercase alphabet, no padding).
// Depends on b32enc_pkg, b32enc_codec, b32enc_outq and the assertion macros.
//
// Usage:
//   Input channel (s_valid/s_ready): one item per handshake. s_command = 0
//   encodes s_data_byte; s_command = 1 ends the message, emitting the last
//   partial 5-bit group (zero-filled on the right) if any bits are left over,
//   and returns the encoder to its empty state. A flush with nothing left
//   produces no character.
//   Result channel (m_valid/m_ready): one ASCII character per handshake
//   (a-z, 2-7). m_last_of_run marks the final character of an item;
//   m_message_tail marks the flushed partial group.
//   Path: an item is registered in the input register at acceptance, grouped
//   when the queue has room and its characters are registered in the queue.
//   Throughput: one item per cycle can be taken while the queue has room;
//   sustained rate is set by the one-character-per-cycle result port while
//   m_ready is high, so a byte that yields two characters slows the input (a
//   5-byte block gives 8 characters).
//   Reset (aresetn low, synchronous): bit phase and residual are cleared and
//   both the input register and the result queue are emptied.
//   Receiver stall: characters wait in a three-entry queue; when it holds two
//   or more, the input register stops draining and s_ready drops once it is
//   full. s_ready depends on registers only, never on m_ready.
`include "base32_stream_encoder_macros.svh"
module base32_stream_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_out_char,
    output logic       m_last_of_run,
    output logic       m_message_tail
);
    import b32enc_pkg::*;

    // input register
    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;

    logic       take;       // input register hands its item to the grouping logic
    logic       q_space;    // queue can absorb two more characters
    b32_pair_t  pair;
    b32_res_t   head;

    assign take    = in_valid_reg && q_space;
    assign s_ready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= s_command;
            in_byte_reg <= s_data_byte;
        end
    end

    b32enc_codec u_codec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .command   (in_cmd_reg),
        .data_byte (in_byte_reg),
        .pair      (pair)
    );

    b32enc_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (take),
        .pair    (pair),
        .space   (q_space),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_out_char     = head.out_char;
    assign m_last_of_run  = head.last_of_run;
    assign m_message_tail = head.message_tail;

    `B32_ASSERT_NXT(a_hold_when_full, in_valid_reg && !q_space, in_valid_reg)
    `B32_ASSERT_NOW(a_ready_free, !in_valid_reg, s_ready)
    `B32_ASSERT_NOW(a_char_range, m_valid, m_out_char >= CHAR_2)

endmodule
